/* design/wcolf_pkg.sv */
`timescale 1ns / 1ps

package wcolf_pkg;

   localparam int TIME_W     = 63;
   localparam int OFFS_W     = 56;
   localparam int SLOPE_W    = 32;
   localparam int SPAN_W     = 32;
   localparam int CLAMP_W    = 31;
   localparam int IVL_W      = 32;
   localparam int HELD_W     = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int FRAC_W     = 40;
   localparam int PRESHIFT   = 9;
   localparam int MUL_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPAN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SLOPE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESAMPLE  = 2'd2;

   localparam logic [SPAN_W-1:0]  MIN_SPAN_RST  = 32'd3000000;
   localparam logic [CLAMP_W-1:0] MAX_SLOPE_RST = 31'd439804651;
   localparam logic [IVL_W-1:0]   RESAMPLE_RST  = 32'd500000;
   localparam logic [SLOPE_W-1:0] SLOPE_SAT     = 32'h8000_0000;

   typedef enum logic [4:0] {
      S_IDLE,
      S_P1,
      S_ADIV_LD,
      S_ADIV,
      S_P2_RD,
      S_P2_LOAD,
      S_P2_MUL,
      S_P2_DRAIN,
      S_COEF_LD,
      S_COEF,
      S_CHK,
      S_FITSEL,
      S_SLOPE_DIV,
      S_CLAMP,
      S_BASE_LD,
      S_BASE_DIV,
      S_OUT
   } state_type;

   typedef struct packed {
      logic       wr;
      logic       rd_en;
      logic       p1;
      logic       first;
      logic       adiv_ld;
      logic       anchor_ld;
      logic       dm_ld;
      logic       mul;
      logic [1:0] mul_k;
      logic       coef_ld;
      logic       coef_step;
      logic       chk;
      logic       fitsel;
      logic       slope_step;
      logic       clamp;
      logic       bdiv_ld;
      logic       out_ld;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic fit;
      logic big;
   } stat_type;

endpackage

/* design/wcolf_if.sv */
`timescale 1ns / 1ps

interface wcolf_req_if;
   import wcolf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [TIME_W-1:0]         local_time_us;
   logic signed [OFFS_W-1:0]  offset_us;

   modport source (output valid, output local_time_us, output offset_us, input ready);
   modport sink (input valid, input local_time_us, input offset_us, output ready);
endinterface

interface wcolf_rsp_if;
   import wcolf_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [TIME_W-1:0]         anchor_us;
   logic signed [OFFS_W-1:0]  base_us;
   logic signed [SLOPE_W-1:0] slope_q40;
   logic                      slope_fitted;
   logic [HELD_W-1:0]         samples_held;
   logic [TIME_W-1:0]         next_sample_us;

   modport source (output valid, output anchor_us, output base_us, output slope_q40,
                   output slope_fitted, output samples_held, output next_sample_us,
                   input ready);
   modport sink (input valid, input anchor_us, input base_us, input slope_q40,
                 input slope_fitted, input samples_held, input next_sample_us,
                 output ready);
endinterface

/* design/wcolf_div.sv */
`timescale 1ns / 1ps

module wcolf_div #(
   parameter int DVW = 70,
   parameter int NW  = 7
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [NW-1:0]  divisor,
   output logic           busy,
   output logic [DVW-1:0] quo,
   output logic [NW-1:0]  rem
);
   localparam int CW = $clog2(DVW + 1);

   logic [DVW-1:0] quo_ff, quo_in;
   logic [NW-1:0]  rem_ff, rem_in;
   logic [NW-1:0]  dsr_ff;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [NW:0]    rem_sh;
   logic [NW:0]    rem_sub;
   logic           ge;

   assign rem_sh  = {rem_ff, quo_ff[DVW-1]};
   assign ge      = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = CW'(DVW);
      end else if (cnt_ff != '0) begin
         quo_in = {quo_ff[DVW-2:0], ge};
         rem_in = ge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

   assign busy = cnt_ff != '0;
   assign quo  = quo_ff;
   assign rem  = rem_ff;
endmodule

/* design/wcolf_dp.sv */
`timescale 1ns / 1ps

module wcolf_dp #(
   parameter int DEPTH = 96,
   parameter int NW    = 7,
   parameter int AW    = 7,
   parameter int WW    = 144,
   parameter int DVW   = 70
) (
   input  logic                                clock,
   input  logic                                reset,
   input  wcolf_pkg::cmd_type                  cmd,
   input  logic [AW-1:0]                       rd_addr,
   output wcolf_pkg::stat_type                 stat,
   output logic [NW-1:0]                       n,
   input  logic [wcolf_pkg::TIME_W-1:0]        in_time,
   input  logic signed [wcolf_pkg::OFFS_W-1:0] in_offs,
   input  logic [wcolf_pkg::SPAN_W-1:0]        min_span,
   input  logic [wcolf_pkg::CLAMP_W-1:0]       max_slope,
   input  logic [wcolf_pkg::IVL_W-1:0]         interval,
   output logic [wcolf_pkg::TIME_W-1:0]        anchor_us,
   output logic signed [wcolf_pkg::OFFS_W-1:0] base_us,
   output logic signed [wcolf_pkg::SLOPE_W-1:0] slope_q40,
   output logic                                slope_fitted,
   output logic [wcolf_pkg::HELD_W-1:0]        samples_held,
   output logic [wcolf_pkg::TIME_W-1:0]        next_sample_us
);
   import wcolf_pkg::*;

   localparam int SYW = OFFS_W + NW;
   localparam int FW  = SYW + 1;

   // sample ring
   logic [TIME_W-1:0] ring_lt  [DEPTH];
   logic [OFFS_W-1:0] ring_off [DEPTH];

   logic [AW-1:0]     slot_ff;
   logic [NW-1:0]     fill_ff;
   logic [TIME_W-1:0] x_ff;
   logic [TIME_W-1:0] rd_lt_ff;
   logic [OFFS_W-1:0] rd_off_ff;

   logic              p1_vld_ff, p1_first_ff;
   logic [TIME_W-1:0] min_ff, max_ff;
   logic [DVW-1:0]    sumx_ff;

   logic [TIME_W-1:0] anchor_ff;
   logic [NW-1:0]     sx_ff;

   logic [TIME_W-1:0] dm_ff;
   logic [OFFS_W-1:0] ym_ff;
   logic              sgn_ff;
   logic signed [SYW-1:0] sy_ff;

   logic [2*MUL_W-1:0] pp_xx_ff, pp_xy_ff;
   logic [1:0]        pp_sh_ff;
   logic              pp_sgn_ff, pp_vld_ff;

   logic [WW-1:0]     sxx_ff, sxy_ff, den_ff, num_ff, m_ff;
   logic signed [WW-1:0] sy_sh_ff;
   logic [NW-1:0]     n_sh_ff, sx_sh_ff;

   logic              fit_ff, neg_ff, fneg_ff;
   logic [SLOPE_W-1:0] q_ff;

   // divider
   logic              div_start, div_busy;
   logic [DVW-1:0]    div_dividend, div_quo;
   logic [NW-1:0]     div_rem;

   // combinational helpers
   logic              dneg;
   logic [TIME_W-1:0] dm_new;
   logic              yneg;
   logic [OFFS_W-1:0] ym_new;
   logic [MUL_W-1:0]  opa, opb_x, opb_y;
   logic [WW-1:0]     xx_ext, xy_ext;
   logic [2*NW-1:0]   sxsq;
   logic [TIME_W-1:0] span;
   logic              fit_cond;
   logic [WW-1:0]     m2;
   logic              dec;
   logic signed [FW-1:0]  f;
   logic signed [DVW-1:0] f_ext;
   logic [DVW-1:0]    bdiv_val;
   logic [TIME_W:0]   next_sum;
   logic [OFFS_W-1:0] bq;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         ring_lt[slot_ff]  <= in_time;
         ring_off[slot_ff] <= in_offs;
      end
      if (cmd.rd_en) begin
         rd_lt_ff  <= ring_lt[rd_addr];
         rd_off_ff <= ring_off[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff     <= '0;
         fill_ff     <= '0;
         p1_vld_ff   <= 1'b0;
         p1_first_ff <= 1'b0;
         pp_vld_ff   <= 1'b0;
      end else begin
         if (cmd.wr) begin
            slot_ff <= (slot_ff == AW'(DEPTH - 1)) ? '0 : slot_ff + AW'(1);
            if (fill_ff != NW'(DEPTH)) begin
               fill_ff <= fill_ff + NW'(1);
            end
         end
         p1_vld_ff   <= cmd.rd_en && cmd.p1;
         p1_first_ff <= cmd.first;
         pp_vld_ff   <= cmd.mul;
      end
   end

   assign n = fill_ff;

   // sample differences and products
   assign dneg   = rd_lt_ff < anchor_ff;
   assign dm_new = dneg ? anchor_ff - rd_lt_ff : rd_lt_ff - anchor_ff;
   assign yneg   = rd_off_ff[OFFS_W-1];
   assign ym_new = yneg ? '0 - rd_off_ff : rd_off_ff;

   assign opa   = cmd.mul_k[1] ? {1'b0, dm_ff[TIME_W-1:MUL_W]} : dm_ff[MUL_W-1:0];
   assign opb_x = cmd.mul_k[0] ? {1'b0, dm_ff[TIME_W-1:MUL_W]} : dm_ff[MUL_W-1:0];
   assign opb_y = cmd.mul_k[0] ? {{(2*MUL_W-OFFS_W){1'b0}}, ym_ff[OFFS_W-1:MUL_W]}
                               : ym_ff[MUL_W-1:0];

   always_comb begin
      case (pp_sh_ff)
         2'd0: begin
            xx_ext = WW'(pp_xx_ff);
            xy_ext = WW'(pp_xy_ff);
         end
         2'd1: begin
            xx_ext = WW'(pp_xx_ff) << MUL_W;
            xy_ext = WW'(pp_xy_ff) << MUL_W;
         end
         default: begin
            xx_ext = WW'(pp_xx_ff) << (2 * MUL_W);
            xy_ext = WW'(pp_xy_ff) << (2 * MUL_W);
         end
      endcase
   end

   assign sxsq     = sx_ff * sx_ff;
   assign span     = max_ff - min_ff;
   assign fit_cond = (span > TIME_W'(min_span)) && !den_ff[WW-1] && (den_ff != '0);
   assign m2       = m_ff << 1;

   assign dec      = fit_ff && !neg_ff && (q_ff != '0) && (sx_ff != '0);
   assign f        = FW'(sy_ff) - FW'(dec);
   assign f_ext    = DVW'(f);
   assign bdiv_val = f[FW-1] ? ('0 - f_ext) + DVW'(fill_ff) - DVW'(1) : f_ext;

   assign stat.div_busy = div_busy;
   assign stat.fit      = fit_ff;
   assign stat.big      = (m_ff << PRESHIFT) >= den_ff;

   assign div_start    = cmd.adiv_ld || cmd.bdiv_ld;
   assign div_dividend = cmd.adiv_ld ? sumx_ff : bdiv_val;

   wcolf_div #(
      .DVW(DVW),
      .NW (NW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (fill_ff),
      .busy    (div_busy),
      .quo     (div_quo),
      .rem     (div_rem)
   );

   assign next_sum = {1'b0, x_ff} + (TIME_W + 1)'(interval);
   assign bq       = div_quo[OFFS_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         x_ff <= in_time;
      end

      if (p1_vld_ff) begin
         if (p1_first_ff) begin
            min_ff  <= rd_lt_ff;
            max_ff  <= rd_lt_ff;
            sumx_ff <= DVW'(rd_lt_ff);
         end else begin
            if (rd_lt_ff < min_ff) begin
               min_ff <= rd_lt_ff;
            end
            if (rd_lt_ff > max_ff) begin
               max_ff <= rd_lt_ff;
            end
            sumx_ff <= sumx_ff + DVW'(rd_lt_ff);
         end
      end

      if (cmd.anchor_ld) begin
         anchor_ff <= div_quo[TIME_W-1:0];
         sx_ff     <= div_rem;
         sy_ff     <= '0;
      end else if (cmd.dm_ld) begin
         sy_ff <= sy_ff + SYW'(signed'(rd_off_ff));
      end

      if (cmd.dm_ld) begin
         dm_ff  <= dm_new;
         ym_ff  <= ym_new;
         sgn_ff <= dneg ^ yneg;
      end

      if (cmd.mul) begin
         pp_xx_ff  <= opa * opb_x;
         pp_xy_ff  <= opa * opb_y;
         pp_sh_ff  <= 2'(cmd.mul_k[1]) + 2'(cmd.mul_k[0]);
         pp_sgn_ff <= sgn_ff;
      end

      if (cmd.anchor_ld) begin
         sxx_ff <= '0;
         sxy_ff <= '0;
      end else if (pp_vld_ff) begin
         sxx_ff <= sxx_ff + xx_ext;
         sxy_ff <= pp_sgn_ff ? sxy_ff - xy_ext : sxy_ff + xy_ext;
      end else if (cmd.coef_step) begin
         sxx_ff <= sxx_ff << 1;
         sxy_ff <= sxy_ff << 1;
      end

      // den = n*sxx - sx^2, num = n*sxy - sy*sx, shift-add over n and sx bits
      if (cmd.coef_ld) begin
         den_ff   <= '0 - WW'(sxsq);
         num_ff   <= '0;
         n_sh_ff  <= fill_ff;
         sx_sh_ff <= sx_ff;
         sy_sh_ff <= WW'(sy_ff);
      end else if (cmd.coef_step) begin
         den_ff   <= den_ff + (n_sh_ff[0] ? sxx_ff : '0);
         num_ff   <= num_ff + (n_sh_ff[0] ? sxy_ff : '0)
                            - (sx_sh_ff[0] ? sy_sh_ff : '0);
         n_sh_ff  <= n_sh_ff >> 1;
         sx_sh_ff <= sx_sh_ff >> 1;
         sy_sh_ff <= sy_sh_ff <<< 1;
      end

      if (cmd.chk) begin
         fit_ff <= fit_cond;
         neg_ff <= fit_cond && num_ff[WW-1];
         m_ff   <= num_ff[WW-1] ? '0 - num_ff : num_ff;
         q_ff   <= '0;
      end else if (cmd.fitsel) begin
         if (fit_ff && stat.big) begin
            q_ff <= SLOPE_SAT;
         end
      end else if (cmd.slope_step) begin
         if (m2 >= den_ff) begin
            m_ff <= m2 - den_ff;
            q_ff <= {q_ff[SLOPE_W-2:0], 1'b1};
         end else begin
            m_ff <= m2;
            q_ff <= {q_ff[SLOPE_W-2:0], 1'b0};
         end
      end else if (cmd.clamp) begin
         if (q_ff > {1'b0, max_slope}) begin
            q_ff <= {1'b0, max_slope};
         end
      end

      if (cmd.bdiv_ld) begin
         fneg_ff <= f[FW-1];
      end

      if (cmd.out_ld) begin
         anchor_us      <= anchor_ff;
         base_us        <= fneg_ff ? '0 - bq : bq;
         slope_q40      <= neg_ff ? '0 - q_ff : q_ff;
         slope_fitted   <= fit_ff;
         samples_held   <= HELD_W'(fill_ff);
         next_sample_us <= next_sum[TIME_W] ? '1 : next_sum[TIME_W-1:0];
      end
   end
endmodule

/* design/wcolf_ctrl.sv */
`timescale 1ns / 1ps

module wcolf_ctrl #(
   parameter int NW   = 7,
   parameter int AW   = 7,
   parameter int CNTW = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [NW-1:0]        n,
   input  wcolf_pkg::stat_type  stat,
   output wcolf_pkg::cmd_type   cmd,
   output logic [AW-1:0]        rd_addr
);
   import wcolf_pkg::*;

   state_type       state_ff, state_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [1:0]      k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [CNTW-1:0] n_c;
   logic [CNTW-1:0] cnt_p1;
   logic [CNTW:0]   cnt_p2;
   logic            last;
   logic            out_free;

   assign n_c      = CNTW'(n);
   assign cnt_p1   = cnt_ff + CNTW'(1);
   assign cnt_p2   = {1'b0, cnt_ff} + (CNTW + 1)'(2);
   assign last     = cnt_p1 == n_c;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      k_in     = k_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_P1;
               cnt_in   = '0;
            end
         end
         S_P1: begin
            if (cnt_ff == n_c) begin
               state_in = S_ADIV_LD;
            end else begin
               cnt_in = cnt_p1;
            end
         end
         S_ADIV_LD: state_in = S_ADIV;
         S_ADIV: begin
            if (!stat.div_busy) begin
               state_in = S_P2_RD;
            end
         end
         S_P2_RD: state_in = S_P2_LOAD;
         S_P2_LOAD: begin
            state_in = S_P2_MUL;
            cnt_in   = '0;
            k_in     = '0;
         end
         S_P2_MUL: begin
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               if (last) begin
                  state_in = S_P2_DRAIN;
               end else begin
                  cnt_in = cnt_p1;
               end
            end
         end
         S_P2_DRAIN: state_in = S_COEF_LD;
         S_COEF_LD: begin
            state_in = S_COEF;
            cnt_in   = '0;
         end
         S_COEF: begin
            if (cnt_ff == CNTW'(NW - 1)) begin
               state_in = S_CHK;
            end else begin
               cnt_in = cnt_p1;
            end
         end
         S_CHK: state_in = S_FITSEL;
         S_FITSEL: begin
            cnt_in = '0;
            if (!stat.fit) begin
               state_in = S_BASE_LD;
            end else if (stat.big) begin
               state_in = S_CLAMP;
            end else begin
               state_in = S_SLOPE_DIV;
            end
         end
         S_SLOPE_DIV: begin
            if (cnt_ff == CNTW'(FRAC_W - 1)) begin
               state_in = S_CLAMP;
            end else begin
               cnt_in = cnt_p1;
            end
         end
         S_CLAMP: state_in = S_BASE_LD;
         S_BASE_LD: state_in = S_BASE_DIV;
         S_BASE_DIV: begin
            if (!stat.div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      rd_addr   = '0;
      req_ready = state_ff == S_IDLE;
      unique case (state_ff)
         S_IDLE: cmd.wr = req_valid;
         S_P1: begin
            if (cnt_ff != n_c) begin
               cmd.rd_en = 1'b1;
               cmd.p1    = 1'b1;
               cmd.first = cnt_ff == '0;
               rd_addr   = cnt_ff[AW-1:0];
            end
         end
         S_ADIV_LD: cmd.adiv_ld = 1'b1;
         S_ADIV: cmd.anchor_ld = !stat.div_busy;
         S_P2_RD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = '0;
         end
         S_P2_LOAD: begin
            cmd.dm_ld = 1'b1;
            if (n_c > CNTW'(1)) begin
               cmd.rd_en = 1'b1;
               rd_addr   = AW'(1);
            end
         end
         S_P2_MUL: begin
            cmd.mul   = 1'b1;
            cmd.mul_k = k_ff;
            if (k_ff == 2'd3 && !last) begin
               cmd.dm_ld = 1'b1;
               if (cnt_p2 < {1'b0, n_c}) begin
                  cmd.rd_en = 1'b1;
                  rd_addr   = cnt_p2[AW-1:0];
               end
            end
         end
         S_COEF_LD:   cmd.coef_ld = 1'b1;
         S_COEF:      cmd.coef_step = 1'b1;
         S_CHK:       cmd.chk = 1'b1;
         S_FITSEL:    cmd.fitsel = 1'b1;
         S_SLOPE_DIV: cmd.slope_step = 1'b1;
         S_CLAMP:     cmd.clamp = 1'b1;
         S_BASE_LD:   cmd.bdiv_ld = 1'b1;
         S_OUT:       cmd.out_ld = out_free;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == S_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* design/windowed_clock_offset_line_fit_core.sv */
// Processing of a beat is set by two passes of ring reads over the held samples, a split
// 32x32 multiply per sample and two bit-serial divisions by n, the number of samples held.
// One beat at a time: the next beat is accepted once the result sits in the output register.
// Synchronous reset clears control state and restores register defaults; ring contents
// are not cleared.
`timescale 1ns / 1ps

module windowed_clock_offset_line_fit_core #(
   parameter int RING_DEPTH = 96
) (
   input  logic                                 clock,
   input  logic                                 reset,
   wcolf_req_if.sink                            req_ch,
   wcolf_rsp_if.source                          rsp_ch,
   input  logic                                 csr_we,
   input  logic [wcolf_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wcolf_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import wcolf_pkg::*;

   localparam int NW   = $clog2(RING_DEPTH + 1);
   localparam int AW   = $clog2(RING_DEPTH);
   localparam int CNTW = (NW > 6) ? NW : 6;
   localparam int WW   = 2 * NW + 130;
   localparam int DVW  = TIME_W + NW;

   logic [SPAN_W-1:0]  min_span_ff;
   logic [CLAMP_W-1:0] max_slope_ff;
   logic [IVL_W-1:0]   interval_ff;

   cmd_type        cmd;
   stat_type       stat;
   logic [AW-1:0]  rd_addr;
   logic [NW-1:0]  n;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_span_ff  <= MIN_SPAN_RST;
         max_slope_ff <= MAX_SLOPE_RST;
         interval_ff  <= RESAMPLE_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MIN_SPAN:  min_span_ff  <= csr_wdata;
            CSR_MAX_SLOPE: max_slope_ff <= csr_wdata[CLAMP_W-1:0];
            CSR_RESAMPLE:  interval_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   wcolf_ctrl #(
      .NW  (NW),
      .AW  (AW),
      .CNTW(CNTW)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .n        (n),
      .stat     (stat),
      .cmd      (cmd),
      .rd_addr  (rd_addr)
   );

   wcolf_dp #(
      .DEPTH(RING_DEPTH),
      .NW   (NW),
      .AW   (AW),
      .WW   (WW),
      .DVW  (DVW)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .stat          (stat),
      .n             (n),
      .in_time       (req_ch.local_time_us),
      .in_offs       (req_ch.offset_us),
      .min_span      (min_span_ff),
      .max_slope     (max_slope_ff),
      .interval      (interval_ff),
      .anchor_us     (rsp_ch.anchor_us),
      .base_us       (rsp_ch.base_us),
      .slope_q40     (rsp_ch.slope_q40),
      .slope_fitted  (rsp_ch.slope_fitted),
      .samples_held  (rsp_ch.samples_held),
      .next_sample_us(rsp_ch.next_sample_us)
   );

   a_busy_after_beat: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("input taken again right after a beat");

   a_window_nonempty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> n != '0)
      else $error("result with empty window");

   a_unfitted_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.slope_fitted |-> rsp_ch.slope_q40 == '0)
      else $error("nonzero slope without fit");

   a_slope_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.slope_fitted |->
         ($signed(rsp_ch.slope_q40) <= $signed({1'b0, max_slope_ff})) &&
         ($signed(rsp_ch.slope_q40) >= -$signed({1'b0, max_slope_ff})))
      else $error("slope beyond clamp");
endmodule

/* dv/windowed_clock_offset_line_fit_core_tb.sv */
`timescale 1ns / 1ps

module windowed_clock_offset_line_fit_core_tb;
   import wcolf_pkg::*;

   localparam int RING_DEPTH = 96;
   localparam int ITEMS_PER_PHASE = 195;
   localparam int NUM_PHASES = 6;
   localparam int DRAIN_CYCLES = 800;
   localparam int LONG_HOLD = 3000;
   localparam longint CYCLE_LIMIT = 8000000;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [OFFS_W-1:0] OFFS_MIN = {1'b1, {(OFFS_W-1){1'b0}}};
   localparam logic [OFFS_W-1:0] OFFS_MAX = {1'b0, {(OFFS_W-1){1'b1}}};

   typedef logic signed [191:0] acc_type;
   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      logic [TIME_W-1:0]         anchor;
      logic signed [OFFS_W-1:0]  base;
      logic [SLOPE_W-1:0]        slope;
      logic                      fitted;
      logic [HELD_W-1:0]         held;
      logic [TIME_W-1:0]         next_due;
   } line_type;

   typedef struct {
      logic [TIME_W-1:0] t;
      logic [OFFS_W-1:0] y;
      bit                typed;
      line_type          line;
   } sample_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MIN_SPAN;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wcolf_req_if req ();
   wcolf_rsp_if rsp ();

   windowed_clock_offset_line_fit_core #(.RING_DEPTH(RING_DEPTH)) uut (
      .clock(clock), .reset(reset), .req_ch(req), .rsp_ch(rsp),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow of the window and registers
   logic [TIME_W-1:0] win_time [RING_DEPTH];
   logic [OFFS_W-1:0] win_offs [RING_DEPTH];
   int unsigned win_slot = 0;
   int unsigned win_fill = 0;
   logic [SPAN_W-1:0]  span_thresh = MIN_SPAN_RST;
   logic [CLAMP_W-1:0] slope_limit = MAX_SLOPE_RST;
   logic [IVL_W-1:0]   resample_ivl = RESAMPLE_RST;

   line_type pending_lines [$];
   int errors = 0;
   longint cycles = 0;
   idle_mode_type idle_mode = IDLE_NONE;
   bit long_hold_req = 0;

   function automatic line_type fit_line(logic [TIME_W-1:0] t, logic [OFFS_W-1:0] y);
      logic [191:0] sumx, mu, den_u, bq;
      logic [TIME_W-1:0] minx, maxx, v;
      acc_type nw, sxw, dx, sxx, sxy, sy, den, num, tq, f;
      logic [63:0] nxt;
      logic [31:0] q;
      bit neg;
      line_type r;
      win_time[win_slot] = t;
      win_offs[win_slot] = y;
      win_slot = (win_slot + 1) % RING_DEPTH;
      if (win_fill < RING_DEPTH) win_fill++;
      nw = win_fill;
      sumx = '0;
      minx = win_time[0];
      maxx = win_time[0];
      for (int i = 0; i < win_fill; i++) begin
         v = win_time[i];
         if (v < minx) minx = v;
         if (v > maxx) maxx = v;
         sumx += v;
      end
      r.anchor = TIME_W'(sumx / win_fill);
      sxw = sumx % win_fill;
      sxx = '0; sxy = '0; sy = '0;
      for (int i = 0; i < win_fill; i++) begin
         dx = $signed({129'b0, win_time[i]}) - $signed({129'b0, r.anchor});
         sxx += dx * dx;
         sxy += dx * $signed({{136{win_offs[i][OFFS_W-1]}}, win_offs[i]});
         sy  += $signed({{136{win_offs[i][OFFS_W-1]}}, win_offs[i]});
      end
      den = nw * sxx - sxw * sxw;
      num = nw * sxy - sy * sxw;
      q = '0;
      neg = 0;
      r.fitted = 0;
      if ({1'b0, maxx - minx} > {32'b0, span_thresh} && den > 0) begin
         r.fitted = 1;
         neg = num < 0;
         mu = neg ? -num : num;
         den_u = den;
         if ((mu << PRESHIFT) >= den_u) q = SLOPE_SAT;
         else q = 32'((mu << FRAC_W) / den_u);
         if (q > {1'b0, slope_limit}) q = {1'b0, slope_limit};
      end
      r.slope = neg ? -q : q;
      tq = (sy <<< FRAC_W) - (neg ? -(acc_type'(q) * sxw) : acc_type'(q) * sxw);
      f = tq >>> FRAC_W;
      if (f < 0) bq = -((192'(-f) + win_fill - 1) / win_fill);
      else bq = 192'(f) / win_fill;
      r.base = bq[OFFS_W-1:0];
      r.held = win_fill[HELD_W-1:0];
      nxt = {1'b0, t} + resample_ivl;
      r.next_due = (nxt > {1'b0, TIME_MAX}) ? TIME_MAX : nxt[TIME_W-1:0];
      return r;
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         CSR_MIN_SPAN:  span_thresh = val;
         CSR_MAX_SLOPE: slope_limit = val[CLAMP_W-1:0];
         CSR_RESAMPLE:  resample_ivl = val;
         default: ;
      endcase
   endtask

   // called right after a rising edge; leaves the beat accepted
   task automatic send_sample(sample_row_type row);
      line_type l;
      @(negedge clock);
      if (idle_mode inside {IDLE_SEND, IDLE_BOTH}) begin
         while ($urandom_range(0, 99) < (idle_mode == IDLE_SEND ? 83 : 12)) begin
            req.valid = 1'b0;
            @(negedge clock);
         end
      end
      req.valid = 1'b1;
      req.local_time_us = row.t;
      req.offset_us = row.y;
      do @(posedge clock); while (!req.ready);
      l = fit_line(row.t, row.y);
      pending_lines.push_back(row.typed ? row.line : l);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending_lines.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (long_hold_req) begin
         rsp.ready = 1'b0;
         repeat (LONG_HOLD) @(negedge clock);
         long_hold_req = 0;
      end
      case (idle_mode)
         IDLE_RECV: rsp.ready = $urandom_range(0, 99) >= 83;
         IDLE_BOTH: rsp.ready = $urandom_range(0, 99) >= 12;
         default:   rsp.ready = 1'b1;
      endcase
   end

   always @(posedge clock) begin
      line_type e;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_lines.size() == 0) begin
            $display("%0t: unexpected beat anchor=%0d base=%0d", $realtime, rsp.anchor_us,
                     rsp.base_us);
            errors++;
         end else begin
            e = pending_lines.pop_front();
            if (rsp.anchor_us !== e.anchor) begin
               $display("%0t: anchor exp %0d got %0d", $realtime, e.anchor, rsp.anchor_us);
               errors++;
            end
            if (rsp.base_us !== e.base) begin
               $display("%0t: base exp %0d got %0d", $realtime, e.base, rsp.base_us);
               errors++;
            end
            if (rsp.slope_q40 !== e.slope) begin
               $display("%0t: slope exp %0d got %0d", $realtime, $signed(e.slope),
                        rsp.slope_q40);
               errors++;
            end
            if (rsp.slope_fitted !== e.fitted) begin
               $display("%0t: fitted exp %0b got %0b", $realtime, e.fitted, rsp.slope_fitted);
               errors++;
            end
            if (rsp.samples_held !== e.held) begin
               $display("%0t: held exp %0d got %0d", $realtime, e.held, rsp.samples_held);
               errors++;
            end
            if (rsp.next_sample_us !== e.next_due) begin
               $display("%0t: next exp %0d got %0d", $realtime, e.next_due,
                        rsp.next_sample_us);
               errors++;
            end
         end
      end
   end

   initial begin
      sample_row_type rows [$];
      sample_row_type row;
      logic [TIME_W-1:0] cur_t;
      logic signed [OFFS_W-1:0] cur_off;
      int drift;
      req.valid = 1'b0;
      req.local_time_us = '0;
      req.offset_us = '0;
      rsp.ready = 1'b1;
      row.typed = 0;
      row.line = '0;

      // first beat after reset: line is the sample itself, next time saturates
      row = '{t: TIME_MAX, y: OFFS_MIN, typed: 1,
              line: '{anchor: TIME_MAX, base: OFFS_MIN, slope: '0, fitted: 0,
                      held: 7'd1, next_due: TIME_MAX}};
      rows.push_back(row);
      row.typed = 0;
      row.line = '0;
      row.t = TIME_MAX; row.y = OFFS_MAX; rows.push_back(row);   // equal times
      row.t = '0;       row.y = '0;       rows.push_back(row);   // huge span, clamp
      row.t = 63'd1000000; row.y = -56'sd1;                rows.push_back(row);
      row.t = 63'd2000000; row.y = 56'sd1;                 rows.push_back(row);
      row.t = 63'd3000000; row.y = 56'sd12345;             rows.push_back(row);
      row.t = 63'd4000000; row.y = -56'sd500000;           rows.push_back(row);
      row.t = 63'd4500000; row.y = OFFS_MAX;               rows.push_back(row);
      row.t = 63'd5000000; row.y = 56'sd100;               rows.push_back(row);
      row.t = 63'd5500000; row.y = -56'sd100;              rows.push_back(row);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i]) send_sample(rows[i]);
      wait_idle();

      cur_t = 63'd6000000;
      cur_off = '0;
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            1: begin
               write_reg(CSR_MIN_SPAN, '0);
               write_reg(CSR_MAX_SLOPE, {1'b0, {CLAMP_W{1'b1}}});
               write_reg(CSR_RESAMPLE, '1);
            end
            2: begin
               write_reg(CSR_MIN_SPAN, '1);
               write_reg(CSR_MAX_SLOPE, '0);
               write_reg(CSR_RESAMPLE, '0);
               long_hold_req = 1;
            end
            3: begin
               write_reg(CSR_MIN_SPAN, $urandom_range(0, 20000000));
               write_reg(CSR_MAX_SLOPE, $urandom);
               write_reg(CSR_RESAMPLE, $urandom);
            end
            4: begin
               write_reg(CSR_MIN_SPAN, '0);
               write_reg(CSR_MAX_SLOPE, '0);
            end
            5: begin
               write_reg(CSR_MIN_SPAN, MIN_SPAN_RST);
               write_reg(CSR_MAX_SLOPE, {1'b0, MAX_SLOPE_RST});
               write_reg(CSR_RESAMPLE, RESAMPLE_RST);
            end
            default: ;
         endcase
         idle_mode = idle_mode_type'(p % 4);
         drift = $urandom_range(0, 400) - 200;
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if ($urandom_range(0, 99) < 85) begin
               if ($urandom_range(0, 19) != 0) cur_t += $urandom_range(300000, 700000);
               cur_off += drift + $signed($urandom_range(0, 2000)) - 1000;
               row.t = cur_t;
               row.y = cur_off;
            end else begin
               row.t = TIME_W'({$urandom, $urandom});
               row.y = OFFS_W'({$urandom, $urandom});
               if ($urandom_range(0, 3) == 0) begin
                  cur_t = row.t;
                  cur_off = row.y;
               end
            end
            send_sample(row);
         end
         wait_idle();
      end

      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
